/* src/prov_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prov_pkg
// shared types and constants for the scene selector with overlay stack
// ----------------------------------------------------------------------------
package prov_pkg;

  localparam int SLOT_COUNT_DEF    = 16;
  localparam int OVERLAY_DEPTH_DEF = 4;

  // slot counters are as wide as the committed length field
  localparam int SLOT_CNT_W = 5;

  typedef enum logic [2:0] {
    FUNC_TICK     = 3'd0,
    FUNC_ACTIVATE = 3'd1,
    FUNC_PUSH     = 3'd2,
    FUNC_WRITE    = 3'd3,
    FUNC_COMMIT   = 3'd4
  } func_e;

  typedef struct packed {
    logic [7:0]  scene;
    logic        enabled;
    logic        present;
    logic [31:0] dwell;
  } slot_t;

  typedef struct packed {
    logic [7:0]  scene;
    logic [7:0]  prio;
    logic [31:0] order;
    logic [31:0] dur;
  } ovl_t;

  localparam int SLOT_W = $bits(slot_t);
  localparam int OVL_W  = $bits(ovl_t);

  typedef struct packed {
    logic       accepted;
    logic [7:0] prev_scene;
    logic       prev_valid;
    logic       scene_changed;
    logic [7:0] shown_scene;
    logic       scene_valid;
  } res_t;

endpackage

/* src/prov_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prov_ram
// single write port, single read port memory with registered read data
// ----------------------------------------------------------------------------
module prov_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  parameter int AW    = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/prov_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prov_ctrl
// sequencer that walks the slot and overlay memories for ticks and activates
// ----------------------------------------------------------------------------
module prov_ctrl import prov_pkg::*; #(
  parameter int SLOT_COUNT    = SLOT_COUNT_DEF,
  parameter int OVERLAY_DEPTH = OVERLAY_DEPTH_DEF,
  parameter int SLOT_AW       = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1,
  parameter int OVL_AW        = (OVERLAY_DEPTH > 1) ? $clog2(OVERLAY_DEPTH) : 1,
  parameter int OVL_CW        = $clog2(OVERLAY_DEPTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         func_i,
  input  logic [31:0]        now_ms_i,
  input  logic [7:0]         scene_id_i,
  input  logic               scene_present_i,
  input  logic               slot_enabled_i,
  input  logic [31:0]        duration_ms_i,
  input  logic [7:0]         priority_req_i,
  input  logic [3:0]         slot_index_i,
  input  logic [4:0]         playlist_length_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output res_t               res_o,
  output logic               slot_we_o,
  output logic [SLOT_AW-1:0] slot_waddr_o,
  output logic [SLOT_W-1:0]  slot_wdata_o,
  output logic [SLOT_AW-1:0] slot_raddr_o,
  input  logic [SLOT_W-1:0]  slot_rdata_i,
  output logic               ovl_we_o,
  output logic [OVL_AW-1:0]  ovl_waddr_o,
  output logic [OVL_W-1:0]   ovl_wdata_o,
  output logic [OVL_AW-1:0]  ovl_raddr_o,
  input  logic [OVL_W-1:0]   ovl_rdata_i
);

  typedef enum logic [16:0] {
    S_IDLE     = 17'h00001,
    S_OV_RD    = 17'h00002,
    S_OV_CMP   = 17'h00004,
    S_OV_EVAL  = 17'h00008,
    S_SH_RD    = 17'h00010,
    S_SH_WR    = 17'h00020,
    S_PL_START = 17'h00040,
    S_PL_CHK1  = 17'h00080,
    S_ADV_RD   = 17'h00100,
    S_ADV_CHK  = 17'h00200,
    S_PL_RD2   = 17'h00400,
    S_PL_CHK2  = 17'h00800,
    S_PL_RD3   = 17'h01000,
    S_PL_CHK3  = 17'h02000,
    S_ACT_RD   = 17'h04000,
    S_ACT_CHK  = 17'h08000,
    S_OUT      = 17'h10000
  } state_e;

  state_e state_q, state_d;
  func_e  func_q, func_d;
  logic [31:0] now_q, now_d, dur_q, dur_d;
  logic [7:0]  sid_q, sid_d;

  logic [SLOT_CNT_W-1:0] siu_q, siu_d, active_q, active_d, pslot_q, pslot_d;
  logic [SLOT_CNT_W-1:0] cand_q, cand_d, cnt_q, cnt_d;
  logic [OVL_CW-1:0]     held_q, held_d, scan_q, scan_d;
  logic [OVL_AW-1:0]     best_idx_q, best_idx_d, run_idx_q, run_idx_d;
  logic [31:0] order_q, order_d, start_q, start_d, fdwell_q, fdwell_d;
  logic [31:0] pdwell_q, pdwell_d, run_start_q, run_start_d;
  logic due_q, due_d, forced_q, forced_d, pend_q, pend_d, restart_q, restart_d;
  logic run_valid_q, run_valid_d, best_valid_q, best_valid_d;
  logic adv_late_q, adv_late_d, last_valid_q, last_valid_d;
  logic rv_q, rv_d, acc_q, acc_d;
  logic [7:0] last_id_q, last_id_d, rid_q, rid_d;
  ovl_t best_q, best_d;

  slot_t slot_rd;
  ovl_t  ovl_rd, ovl_new;
  slot_t slot_new;
  logic  slot_ok;
  logic [31:0] dwell;
  logic [31:0] ov_start;
  logic [SLOT_CNT_W-1:0] act_tmp;

  assign slot_rd = slot_t'(slot_rdata_i);
  assign ovl_rd  = ovl_t'(ovl_rdata_i);
  assign slot_ok = slot_rd.present & slot_rd.enabled;

  function automatic logic [SLOT_CNT_W-1:0] next_slot(
    input logic [SLOT_CNT_W-1:0] x, input logic [SLOT_CNT_W-1:0] n);
    logic [SLOT_CNT_W-1:0] y;
    y = x + 1'b1;
    return (y == n) ? '0 : y;
  endfunction

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_OUT);

  always_comb begin
    res_o = '0;
    if (func_q == FUNC_TICK) begin
      res_o.scene_valid   = rv_q;
      res_o.shown_scene   = rv_q ? rid_q : 8'd0;
      res_o.scene_changed = (rv_q != last_valid_q) || (rv_q && (rid_q != last_id_q));
      res_o.prev_valid    = last_valid_q;
      res_o.prev_scene    = last_valid_q ? last_id_q : 8'd0;
    end else begin
      res_o.accepted = acc_q;
    end
  end

  always_comb begin
    state_d = state_q; func_d = func_q; now_d = now_q; dur_d = dur_q; sid_d = sid_q;
    siu_d = siu_q; active_d = active_q; pslot_d = pslot_q; cand_d = cand_q; cnt_d = cnt_q;
    held_d = held_q; scan_d = scan_q; best_idx_d = best_idx_q; run_idx_d = run_idx_q;
    order_d = order_q; start_d = start_q; fdwell_d = fdwell_q; pdwell_d = pdwell_q;
    run_start_d = run_start_q; due_d = due_q; forced_d = forced_q; pend_d = pend_q;
    restart_d = restart_q; run_valid_d = run_valid_q; best_valid_d = best_valid_q;
    adv_late_d = adv_late_q; last_valid_d = last_valid_q; last_id_d = last_id_q;
    rv_d = rv_q; acc_d = acc_q; rid_d = rid_q; best_d = best_q;

    slot_we_o    = 1'b0;
    slot_waddr_o = SLOT_AW'(slot_index_i);
    slot_new.scene   = scene_id_i;
    slot_new.enabled = slot_enabled_i;
    slot_new.present = scene_present_i;
    slot_new.dwell   = duration_ms_i;
    slot_wdata_o = slot_new;
    slot_raddr_o = SLOT_AW'(active_q);
    ovl_we_o     = 1'b0;
    ovl_waddr_o  = OVL_AW'(held_q);
    ovl_new.scene = scene_id_i;
    ovl_new.prio  = priority_req_i;
    ovl_new.order = order_q;
    ovl_new.dur   = duration_ms_i;
    ovl_wdata_o  = ovl_new;
    ovl_raddr_o  = OVL_AW'(scan_q);
    dwell    = slot_rd.dwell;
    ov_start = now_q;
    act_tmp  = active_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          func_d = func_e'(func_i);
          now_d  = now_ms_i;
          dur_d  = duration_ms_i;
          sid_d  = scene_id_i;
          acc_d  = 1'b0;
          state_d = S_OUT;
          unique case (func_e'(func_i))
            FUNC_TICK: begin
              if (pend_q) begin
                active_d = pslot_q;
                forced_d = 1'b1;
                fdwell_d = pdwell_q;
                due_d    = 1'b1;
                pend_d   = 1'b0;
              end
              scan_d       = '0;
              best_valid_d = 1'b0;
              state_d      = S_OV_RD;
            end
            FUNC_ACTIVATE: begin
              cand_d  = '0;
              state_d = S_ACT_RD;
            end
            FUNC_PUSH: begin
              if (held_q < OVL_CW'(OVERLAY_DEPTH)) begin
                ovl_we_o = 1'b1;
                order_d  = order_q + 32'd1;
                held_d   = held_q + 1'b1;
                acc_d    = 1'b1;
              end
            end
            FUNC_WRITE: begin
              slot_we_o = ({5'd0, slot_index_i} < 9'(SLOT_COUNT));
            end
            FUNC_COMMIT: begin
              siu_d = ({4'd0, playlist_length_i} > 9'(SLOT_COUNT)) ?
                      SLOT_CNT_W'(SLOT_COUNT) : playlist_length_i;
              active_d = '0;
              due_d    = 1'b1;
              forced_d = 1'b0;
              fdwell_d = '0;
              pend_d   = 1'b0;
            end
            default: ;
          endcase
        end
      end

      // find the top overlay: highest priority, oldest on a tie
      S_OV_RD: begin
        if (scan_q >= held_q) begin
          state_d = S_OV_EVAL;
        end else begin
          state_d = S_OV_CMP;
        end
      end
      S_OV_CMP: begin
        if (!best_valid_q || (ovl_rd.prio > best_q.prio) ||
            ((ovl_rd.prio == best_q.prio) && (ovl_rd.order < best_q.order))) begin
          best_d       = ovl_rd;
          best_idx_d   = OVL_AW'(scan_q);
          best_valid_d = 1'b1;
        end
        scan_d  = scan_q + 1'b1;
        state_d = S_OV_RD;
      end
      S_OV_EVAL: begin
        if (!best_valid_q) begin
          run_valid_d = 1'b0;
          state_d     = S_PL_START;
        end else begin
          if (run_valid_q && (run_idx_q == best_idx_q)) begin
            ov_start = run_start_q;
          end
          if ((now_q - ov_start) >= best_q.dur) begin
            run_valid_d = 1'b0;
            scan_d      = OVL_CW'(best_idx_q) + 1'b1;
            state_d     = S_SH_RD;
          end else begin
            run_valid_d = 1'b1;
            run_idx_d   = best_idx_q;
            run_start_d = ov_start;
            restart_d   = 1'b1;
            rv_d        = 1'b1;
            rid_d       = best_q.scene;
            state_d     = S_OUT;
          end
        end
      end

      // drop the expired top overlay by moving later entries down one place
      S_SH_RD: begin
        if (scan_q >= held_q) begin
          held_d       = held_q - 1'b1;
          scan_d       = '0;
          best_valid_d = 1'b0;
          state_d      = S_OV_RD;
        end else begin
          state_d = S_SH_WR;
        end
      end
      S_SH_WR: begin
        ovl_we_o    = 1'b1;
        ovl_waddr_o = OVL_AW'(scan_q - 1'b1);
        ovl_wdata_o = ovl_rd;
        scan_d      = scan_q + 1'b1;
        state_d     = S_SH_RD;
      end

      // playlist selection
      S_PL_START: begin
        if (siu_q == '0) begin
          rv_d    = 1'b0;
          state_d = S_OUT;
        end else begin
          if (active_q >= siu_q) begin
            act_tmp  = '0;
            due_d    = 1'b1;
            forced_d = 1'b0;
          end
          if (restart_q) begin
            due_d     = 1'b1;
            restart_d = 1'b0;
          end
          active_d     = act_tmp;
          slot_raddr_o = SLOT_AW'(act_tmp);
          state_d      = S_PL_CHK1;
        end
      end
      S_PL_CHK1: begin
        if (!forced_q && !slot_ok) begin
          cnt_d      = SLOT_CNT_W'(1);
          cand_d     = next_slot(active_q, siu_q);
          adv_late_d = 1'b0;
          state_d    = S_ADV_RD;
        end else begin
          state_d = S_PL_RD2;
        end
      end
      S_ADV_RD: begin
        slot_raddr_o = SLOT_AW'(cand_q);
        state_d      = S_ADV_CHK;
      end
      S_ADV_CHK: begin
        if (slot_ok) begin
          active_d = cand_q;
          if (adv_late_q) begin
            start_d = now_q;
            state_d = S_PL_RD3;
          end else begin
            due_d   = 1'b1;
            state_d = S_PL_RD2;
          end
        end else if (cnt_q == siu_q) begin
          rv_d    = 1'b0;
          state_d = S_OUT;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          cand_d  = next_slot(cand_q, siu_q);
          state_d = S_ADV_RD;
        end
      end
      S_PL_RD2: begin
        if (due_q) begin
          start_d = now_q;
          due_d   = 1'b0;
        end
        state_d = S_PL_CHK2;
      end
      S_PL_CHK2: begin
        if (forced_q && (fdwell_q != '0)) begin
          dwell = fdwell_q;
        end
        if ((now_q - start_q) >= dwell) begin
          forced_d   = 1'b0;
          cnt_d      = SLOT_CNT_W'(1);
          cand_d     = next_slot(active_q, siu_q);
          adv_late_d = 1'b1;
          state_d    = S_ADV_RD;
        end else begin
          state_d = S_PL_RD3;
        end
      end
      S_PL_RD3: begin
        state_d = S_PL_CHK3;
      end
      S_PL_CHK3: begin
        rv_d    = slot_rd.present;
        rid_d   = slot_rd.scene;
        state_d = S_OUT;
      end

      // activate: lowest present slot in use with a matching scene
      S_ACT_RD: begin
        slot_raddr_o = SLOT_AW'(cand_q);
        if (cand_q >= siu_q) begin
          state_d = S_OUT;
        end else begin
          state_d = S_ACT_CHK;
        end
      end
      S_ACT_CHK: begin
        if (slot_rd.present && (slot_rd.scene == sid_q)) begin
          pend_d   = 1'b1;
          pslot_d  = cand_q;
          pdwell_d = dur_q;
          acc_d    = 1'b1;
          state_d  = S_OUT;
        end else begin
          cand_d  = cand_q + 1'b1;
          state_d = S_ACT_RD;
        end
      end

      S_OUT: begin
        if (res_ready_i) begin
          if (func_q == FUNC_TICK) begin
            last_valid_d = rv_q;
            last_id_d    = rv_q ? rid_q : 8'd0;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      siu_q        <= '0;
      active_q     <= '0;
      pslot_q      <= '0;
      held_q       <= '0;
      order_q      <= '0;
      start_q      <= '0;
      fdwell_q     <= '0;
      pdwell_q     <= '0;
      due_q        <= 1'b1;
      forced_q     <= 1'b0;
      pend_q       <= 1'b0;
      restart_q    <= 1'b0;
      run_valid_q  <= 1'b0;
      last_valid_q <= 1'b0;
      last_id_q    <= '0;
    end else begin
      state_q      <= state_d;
      siu_q        <= siu_d;
      active_q     <= active_d;
      pslot_q      <= pslot_d;
      held_q       <= held_d;
      order_q      <= order_d;
      start_q      <= start_d;
      fdwell_q     <= fdwell_d;
      pdwell_q     <= pdwell_d;
      due_q        <= due_d;
      forced_q     <= forced_d;
      pend_q       <= pend_d;
      restart_q    <= restart_d;
      run_valid_q  <= run_valid_d;
      last_valid_q <= last_valid_d;
      last_id_q    <= last_id_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    now_q        <= now_d;
    dur_q        <= dur_d;
    sid_q        <= sid_d;
    cand_q       <= cand_d;
    cnt_q        <= cnt_d;
    scan_q       <= scan_d;
    best_idx_q   <= best_idx_d;
    run_idx_q    <= run_idx_d;
    run_start_q  <= run_start_d;
    best_valid_q <= best_valid_d;
    adv_late_q   <= adv_late_d;
    rv_q         <= rv_d;
    acc_q        <= acc_d;
    rid_q        <= rid_d;
    best_q       <= best_d;
  end

endmodule

/* src/priority_overlay_playlist_rotator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_overlay_playlist_rotator
// time-sliced scene selector with a preemptive overlay stack
// ----------------------------------------------------------------------------
// usage:
//   items enter on the s_axis channel, tuser carries the item kind (tick,
//   activate, push overlay, write slot, commit) and tdata the fields. every
//   item gives exactly one result transfer on the m_axis channel.
//   slot table and overlay stack live in two memories with registered reads;
//   a sequencer walks them one entry at a time.
//   work per item: write slot, commit and push are handled in the idle
//   state; activate searches the slots in use; a tick searches the held
//   overlays, removes each expired top overlay by moving later entries
//   down and searching again, and when no overlay is shown walks the
//   playlist over the slots in use.
//   one item is in work at a time; s_axis_tready is high while idle.
//   the result sits in an output register, so the next item is taken while
//   a result waits; a stalled receiver holds the block once the next result
//   is ready.
//   reset clears the persistent control state: empty playlist, empty overlay stack, no
//   previous scene. memory contents are undefined until written.
// ----------------------------------------------------------------------------
module priority_overlay_playlist_rotator import prov_pkg::*; #(
  parameter int SLOT_COUNT    = SLOT_COUNT_DEF,
  parameter int OVERLAY_DEPTH = OVERLAY_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // now_ms[31:0], scene_id[39:32], scene_present[40], slot_enabled[41],
  // duration_ms[73:42], priority_req[81:74], slot_index[85:82],
  // playlist_length[90:86], zero fill up to 95
  input  logic [95:0] s_axis_tdata,
  // func[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // scene_valid[0], shown_scene[8:1], scene_changed[9], prev_valid[10],
  // prev_scene[18:11], accepted[19], zero fill up to 23
  output logic [23:0] m_axis_tdata
);

  localparam int SLOT_AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int OVL_AW  = (OVERLAY_DEPTH > 1) ? $clog2(OVERLAY_DEPTH) : 1;
  localparam int OVL_CW  = $clog2(OVERLAY_DEPTH + 1);

  logic               res_valid, res_ready;
  res_t               res;
  logic               slot_we;
  logic [SLOT_AW-1:0] slot_waddr, slot_raddr;
  logic [SLOT_W-1:0]  slot_wdata, slot_rdata;
  logic               ovl_we;
  logic [OVL_AW-1:0]  ovl_waddr, ovl_raddr;
  logic [OVL_W-1:0]   ovl_wdata, ovl_rdata;

  // output register: loads whenever it is empty or being drained
  logic  out_valid_q;
  res_t  out_q;

  assign res_ready = !out_valid_q || m_axis_tready;

  prov_ctrl #(
    .SLOT_COUNT   (SLOT_COUNT),
    .OVERLAY_DEPTH(OVERLAY_DEPTH),
    .SLOT_AW      (SLOT_AW),
    .OVL_AW       (OVL_AW),
    .OVL_CW       (OVL_CW)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_o       (s_axis_tready),
    .func_i           (s_axis_tuser),
    .now_ms_i         (s_axis_tdata[31:0]),
    .scene_id_i       (s_axis_tdata[39:32]),
    .scene_present_i  (s_axis_tdata[40]),
    .slot_enabled_i   (s_axis_tdata[41]),
    .duration_ms_i    (s_axis_tdata[73:42]),
    .priority_req_i   (s_axis_tdata[81:74]),
    .slot_index_i     (s_axis_tdata[85:82]),
    .playlist_length_i(s_axis_tdata[90:86]),
    .res_valid_o      (res_valid),
    .res_ready_i      (res_ready),
    .res_o            (res),
    .slot_we_o        (slot_we),
    .slot_waddr_o     (slot_waddr),
    .slot_wdata_o     (slot_wdata),
    .slot_raddr_o     (slot_raddr),
    .slot_rdata_i     (slot_rdata),
    .ovl_we_o         (ovl_we),
    .ovl_waddr_o      (ovl_waddr),
    .ovl_wdata_o      (ovl_wdata),
    .ovl_raddr_o      (ovl_raddr),
    .ovl_rdata_i      (ovl_rdata)
  );

  // slot table: scene, flags and dwell per slot
  prov_ram #(
    .DEPTH(SLOT_COUNT),
    .WIDTH(SLOT_W),
    .AW   (SLOT_AW)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (slot_we),
    .waddr_i(slot_waddr),
    .wdata_i(slot_wdata),
    .raddr_i(slot_raddr),
    .rdata_o(slot_rdata)
  );

  // overlay stack in push order: scene, priority, push order, duration
  prov_ram #(
    .DEPTH(OVERLAY_DEPTH),
    .WIDTH(OVL_W),
    .AW   (OVL_AW)
  ) u_ovl_ram (
    .clk_i  (clk_i),
    .we_i   (ovl_we),
    .waddr_i(ovl_waddr),
    .wdata_i(ovl_wdata),
    .raddr_i(ovl_raddr),
    .rdata_o(ovl_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_q.accepted, out_q.prev_scene, out_q.prev_valid,
                          out_q.scene_changed, out_q.shown_scene, out_q.scene_valid};

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the scene selector with overlay stack
// ----------------------------------------------------------------------------
// items go in on the s_axis stream and results come back on m_axis. a
// behavioral copy of the selector (slot table, overlay stack, rotation and
// forced activation) predicts one result per accepted transfer, and each
// result is checked field by field against the oldest expected one. setup
// items and a short directed table come first, then 1450 random items
// with random gaps and stalls on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import prov_pkg::*;

  localparam int NSLOT = SLOT_COUNT_DEF;
  localparam int NOVL  = OVERLAY_DEPTH_DEF;
  localparam int RANDOM_ITEMS = 1450;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_CYCLES  = 400;

  // codes that the block must ignore
  localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
  localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

  localparam res_t RES_NONE     = '0;
  localparam res_t RES_ACCEPTED = res_t'(20'h80000);

  typedef struct {
    logic [2:0]  func;
    logic [31:0] now;
    logic [7:0]  scene;
    logic        present;
    logic        enabled;
    logic [31:0] dur;
    logic [7:0]  prio;
    logic [3:0]  idx;
    logic [4:0]  len;
  } item_t;

  typedef struct {
    item_t it;
    bit    typed;   // expected result written into the table
    res_t  res;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  always #5 clk_i = ~clk_i;

  priority_overlay_playlist_rotator i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // --------------------------------------------------------------------------
  // scene selector prediction state
  // --------------------------------------------------------------------------
  logic [7:0]  tbl_scene [NSLOT];
  logic        tbl_present [NSLOT];
  logic        tbl_enabled [NSLOT];
  logic [31:0] tbl_dwell [NSLOT];
  int          tbl_len;

  logic [7:0]  ovl_scene [NOVL];
  logic [31:0] ovl_dur [NOVL];
  logic [7:0]  ovl_prio [NOVL];
  logic [31:0] ovl_order [NOVL];
  logic [31:0] ovl_start [NOVL];
  logic        ovl_run [NOVL];
  int          ovl_held;
  logic [31:0] push_seq;

  int          cur_slot;
  bit          restart_slot;
  logic [31:0] slot_t0;
  bit          forced_on;
  logic [31:0] forced_hold;
  bit          act_waiting;
  int          act_slot;
  logic [31:0] act_hold;
  bit          ovl_touched;
  bit          shown_ok;
  logic [7:0]  shown_id;

  res_t scene_fifo [$];   // predicted results still outstanding
  int   err_cnt;
  int   tick_cnt, hit_cnt, result_cnt, sent_cnt;
  bit   held_off;

  function automatic bit rotates(int s);
    return tbl_present[s] && tbl_enabled[s];
  endfunction

  // next enabled, present slot after the current one, wrapping
  function automatic bit next_slot();
    int cand;
    if (tbl_len == 0) return 1'b0;
    for (int k = 1; k <= tbl_len; k++) begin
      cand = (cur_slot + k) % tbl_len;
      if (rotates(cand)) begin
        cur_slot = cand;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // highest priority wins, oldest push on a tie
  function automatic int top_ovl();
    int best;
    best = -1;
    for (int k = 0; k < ovl_held; k++) begin
      if (best < 0) best = k;
      else if (ovl_prio[k] > ovl_prio[best] ||
               (ovl_prio[k] == ovl_prio[best] && ovl_order[k] < ovl_order[best]))
        best = k;
    end
    return best;
  endfunction

  function automatic void drop_ovl(int at);
    for (int k = at + 1; k < ovl_held; k++) begin
      ovl_scene[k-1] = ovl_scene[k];
      ovl_dur[k-1]   = ovl_dur[k];
      ovl_prio[k-1]  = ovl_prio[k];
      ovl_order[k-1] = ovl_order[k];
      ovl_start[k-1] = ovl_start[k];
      ovl_run[k-1]   = ovl_run[k];
    end
    if (ovl_held > 0) ovl_held--;
  endfunction

  function automatic bit playlist_pick(logic [31:0] now, output logic [7:0] id);
    logic [31:0] dwell;
    logic [31:0] spent;
    id = '0;
    if (tbl_len == 0) return 1'b0;
    if (cur_slot >= tbl_len) begin
      cur_slot = 0;
      restart_slot = 1'b1;
      forced_on = 1'b0;
    end
    if (ovl_touched) begin
      restart_slot = 1'b1;
      ovl_touched = 1'b0;
    end
    if (!forced_on && !rotates(cur_slot)) begin
      if (!next_slot()) return 1'b0;
      restart_slot = 1'b1;
    end
    if (restart_slot) begin
      slot_t0 = now;
      restart_slot = 1'b0;
    end
    dwell = tbl_dwell[cur_slot];
    if (forced_on && forced_hold != 0) dwell = forced_hold;
    spent = now - slot_t0;
    if (spent >= dwell) begin
      forced_on = 1'b0;
      if (!next_slot() && !rotates(cur_slot)) return 1'b0;
      slot_t0 = now;
    end
    if (!tbl_present[cur_slot]) return 1'b0;
    id = tbl_scene[cur_slot];
    return 1'b1;
  endfunction

  function automatic res_t predict_scene(item_t it);
    res_t        r;
    int          top;
    bit          ok;
    logic [7:0]  id;
    logic [31:0] spent;
    r = RES_NONE;
    case (it.func)
      FUNC_TICK: begin
        if (act_waiting) begin
          cur_slot = act_slot;
          forced_on = 1'b1;
          forced_hold = act_hold;
          restart_slot = 1'b1;
          act_waiting = 1'b0;
        end
        top = top_ovl();
        while (top >= 0) begin
          if (!ovl_run[top]) begin
            ovl_run[top] = 1'b1;
            ovl_start[top] = it.now;
          end
          spent = it.now - ovl_start[top];
          if (spent >= ovl_dur[top]) begin
            drop_ovl(top);
            top = top_ovl();
          end else begin
            break;
          end
        end
        // only the top overlay's timer runs
        for (int k = 0; k < ovl_held; k++)
          if (k != top) ovl_run[k] = 1'b0;
        if (top >= 0) begin
          ovl_touched = 1'b1;
          ok = 1'b1;
          id = ovl_scene[top];
        end else begin
          ok = playlist_pick(it.now, id);
        end
        if (!ok) id = '0;
        r.scene_valid   = ok;
        r.shown_scene   = id;
        r.scene_changed = (ok != shown_ok) || (ok && id != shown_id);
        r.prev_valid    = shown_ok;
        r.prev_scene    = shown_ok ? shown_id : 8'h00;
        shown_ok = ok;
        shown_id = id;
      end
      FUNC_ACTIVATE: begin
        for (int k = 0; k < tbl_len; k++) begin
          if (tbl_present[k] && tbl_scene[k] == it.scene) begin
            act_waiting = 1'b1;
            act_slot = k;
            act_hold = it.dur;
            r.accepted = 1'b1;
            break;
          end
        end
      end
      FUNC_PUSH: begin
        if (ovl_held < NOVL) begin
          ovl_scene[ovl_held] = it.scene;
          ovl_dur[ovl_held]   = it.dur;
          ovl_prio[ovl_held]  = it.prio;
          ovl_order[ovl_held] = push_seq;
          ovl_start[ovl_held] = '0;
          ovl_run[ovl_held]   = 1'b0;
          push_seq = push_seq + 1;
          ovl_held++;
          r.accepted = 1'b1;
        end
      end
      FUNC_WRITE: begin
        tbl_scene[it.idx]   = it.scene;
        tbl_present[it.idx] = it.present;
        tbl_enabled[it.idx] = it.enabled;
        tbl_dwell[it.idx]   = it.dur;
      end
      FUNC_COMMIT: begin
        tbl_len = (it.len > NSLOT) ? NSLOT : int'(it.len);
        cur_slot = 0;
        restart_slot = 1'b1;
        forced_on = 1'b0;
        forced_hold = '0;
        act_waiting = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // item builders and the sender
  // --------------------------------------------------------------------------
  function automatic item_t mk(logic [2:0] func);
    item_t it;
    it = '{func: func, default: '0};
    return it;
  endfunction

  logic [31:0] clock_ms;   // running tick time for random stimulus

  function automatic item_t rand_item();
    item_t it;
    int    pick;
    it = mk(FUNC_TICK);
    it.now     = $urandom;
    it.scene   = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 15);
    it.present = $urandom_range(0, 5) != 0;
    it.enabled = $urandom_range(0, 4) != 0;
    it.dur     = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 60);
    it.prio    = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3);
    it.idx     = $urandom;
    it.len     = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(1, 16);
    pick = $urandom_range(0, 99);
    if (pick < 48) begin
      it.func = FUNC_TICK;
      case ($urandom_range(0, 19))
        0:       clock_ms = $urandom;
        1:       clock_ms = clock_ms + $urandom;
        default: clock_ms = clock_ms + $urandom_range(0, 25);
      endcase
      it.now = clock_ms;
    end else if (pick < 60) begin
      it.func = FUNC_ACTIVATE;
      // mostly a scene that sits somewhere in the table
      if ($urandom_range(0, 3) != 0) it.scene = tbl_scene[$urandom_range(0, NSLOT - 1)];
    end else if (pick < 74) begin
      it.func = FUNC_PUSH;
    end else if (pick < 91) begin
      it.func = FUNC_WRITE;
    end else if (pick < 97) begin
      it.func = FUNC_COMMIT;
    end else begin
      it.func = 3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
    end
    return it;
  endfunction

  // one transfer on s_axis, expectation queued at acceptance
  task automatic send_item(item_t it, bit typed, res_t typed_res);
    res_t pred;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.func;
    s_axis_tdata  <= {5'b0, it.len, it.idx, it.prio, it.dur, it.enabled,
                      it.present, it.scene, it.now};
    do @(posedge clk_i); while (!s_axis_tready);
    pred = predict_scene(it);
    scene_fifo.push_back(typed ? typed_res : pred);
    sent_cnt++;
    if (it.func == FUNC_TICK) tick_cnt++;
    if (pred.accepted) hit_cnt++;
    // random gap, mostly short, sometimes none, rarely long
    case ($urandom_range(0, 9))
      0, 1, 2, 3: ;
      9: begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(15, 40)) @(posedge clk_i);
      end
      default: begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end
    endcase
  endtask

  row_t dir_rows [$];

  task automatic add_row(item_t it, bit typed, res_t res);
    dir_rows.push_back('{it: it, typed: typed, res: res});
  endtask

  // --------------------------------------------------------------------------
  // receiver: random stalls plus one long hold-off so the block backs up
  // --------------------------------------------------------------------------
  initial begin
    int run;
    wait (rst_ni);
    forever begin
      if (!held_off && sent_cnt >= 300) begin
        held_off = 1'b1;
        m_axis_tready <= 1'b0;
        for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk_i);
      end
      run = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4);
      m_axis_tready <= ($urandom_range(0, 2) != 0);
      repeat (run) @(posedge clk_i);
    end
  end

  // --------------------------------------------------------------------------
  // result checker
  // --------------------------------------------------------------------------
  task automatic cmp_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    res_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = res_t'(m_axis_tdata[19:0]);
      result_cnt++;
      if (scene_fifo.size() == 0) begin
        $display("%0t ns: unexpected result transfer 0x%0h", $time, m_axis_tdata);
        err_cnt++;
      end else begin
        want = scene_fifo.pop_front();
        cmp_field("scene_valid",   want.scene_valid,   got.scene_valid);
        cmp_field("shown_scene",   want.shown_scene,   got.shown_scene);
        cmp_field("scene_changed", want.scene_changed, got.scene_changed);
        cmp_field("prev_valid",    want.prev_valid,    got.prev_valid);
        cmp_field("prev_scene",    want.prev_scene,    got.prev_scene);
        cmp_field("accepted",      want.accepted,      got.accepted);
        cmp_field("zero fill",     0,                  m_axis_tdata[23:20]);
      end
    end
  end

  // hard stop
  initial begin
    #20ms;
    $display("timeout with %0d results outstanding", scene_fifo.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    item_t it;
    tbl_len = 0; ovl_held = 0; push_seq = '0; cur_slot = 0; restart_slot = 1'b1;
    slot_t0 = '0; forced_on = 1'b0; forced_hold = '0; act_waiting = 1'b0;
    act_slot = 0; act_hold = '0; ovl_touched = 1'b0; shown_ok = 1'b0; shown_id = '0;
    err_cnt = 0; tick_cnt = 0; hit_cnt = 0; result_cnt = 0; sent_cnt = 0;
    held_off = 1'b0; clock_ms = '0;
    for (int k = 0; k < NSLOT; k++) tbl_scene[k] = '0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // tick straight after reset, and the spare codes
    it = mk(FUNC_TICK);
    send_item(it, 1'b1, RES_NONE);
    send_item(mk(FUNC_SPARE_LO), 1'b1, RES_NONE);
    send_item(mk(FUNC_SPARE_HI), 1'b1, RES_NONE);

    // fill the whole slot table before anything can read it; 8'hff kept out
    for (int k = 0; k < NSLOT; k++) begin
      it = rand_item();
      it.func = FUNC_WRITE;
      it.idx = 4'(k);
      it.scene = $urandom_range(0, 254);
      send_item(it, 1'b0, RES_NONE);
    end

    // directed table
    it = mk(FUNC_COMMIT);   it.len = 5'd31;                          // capped length
    add_row(it, 1'b1, RES_NONE);
    it = mk(FUNC_ACTIVATE); it.scene = 8'hff;                        // activate miss
    add_row(it, 1'b1, RES_NONE);
    it = mk(FUNC_WRITE); it.idx = 4'd15; it.scene = 8'h00; it.present = 1'b1;
    it.enabled = 1'b1; it.dur = 32'hffff_ffff;
    add_row(it, 1'b1, RES_NONE);
    it = mk(FUNC_WRITE); it.idx = 4'd0; it.scene = 8'hff; it.present = 1'b1;
    add_row(it, 1'b1, RES_NONE);                                     // present, not rotating
    it = mk(FUNC_PUSH); it.scene = 8'ha0;
    add_row(it, 1'b1, RES_ACCEPTED);
    it = mk(FUNC_PUSH); it.scene = 8'ha1; it.dur = 32'd10; it.prio = 8'hff;
    add_row(it, 1'b1, RES_ACCEPTED);
    it = mk(FUNC_PUSH); it.scene = 8'ha2; it.dur = 32'd5; it.prio = 8'hff;  // tie
    add_row(it, 1'b1, RES_ACCEPTED);
    it = mk(FUNC_PUSH); it.scene = 8'ha3; it.dur = 32'd3; it.prio = 8'h80;
    add_row(it, 1'b1, RES_ACCEPTED);
    it = mk(FUNC_PUSH); it.scene = 8'ha4; it.dur = 32'hffff_ffff; it.prio = 8'hff;
    add_row(it, 1'b1, RES_NONE);                                     // stack full
    it = mk(FUNC_ACTIVATE); it.scene = 8'hff;                        // forced slot 0
    add_row(it, 1'b1, RES_ACCEPTED);
    // time wraps while overlays expire one by one
    foreach (dir_rows[k]) ;
    it = mk(FUNC_TICK); it.now = 32'hffff_fff0; add_row(it, 1'b0, RES_NONE);
    it = mk(FUNC_TICK); it.now = 32'h0000_0004; add_row(it, 1'b0, RES_NONE);
    it = mk(FUNC_TICK); it.now = 32'h0000_0009; add_row(it, 1'b0, RES_NONE);
    it = mk(FUNC_TICK); it.now = 32'h0000_000c; add_row(it, 1'b0, RES_NONE);
    it = mk(FUNC_TICK); it.now = 32'h0000_000c; add_row(it, 1'b0, RES_NONE);
    it = mk(FUNC_WRITE); it.idx = 4'd15; it.scene = 8'h00;           // drop the slot
    add_row(it, 1'b0, RES_NONE);
    it = mk(FUNC_TICK); it.now = 32'h7fff_ffff; add_row(it, 1'b0, RES_NONE);
    it = mk(FUNC_SPARE_LO); it.now = 32'hffff_ffff; add_row(it, 1'b1, RES_NONE);
    it = mk(FUNC_COMMIT);   it.len = 5'd0;  add_row(it, 1'b1, RES_NONE);
    it = mk(FUNC_TICK); it.now = 32'hffff_ffff; add_row(it, 1'b0, RES_NONE);
    it = mk(FUNC_COMMIT);   it.len = 5'd16; add_row(it, 1'b1, RES_NONE);
    foreach (dir_rows[k]) send_item(dir_rows[k].it, dir_rows[k].typed, dir_rows[k].res);

    // random part
    for (int n = 0; n < RANDOM_ITEMS; n++) send_item(rand_item(), 1'b0, RES_NONE);
    s_axis_tvalid <= 1'b0;

    while (scene_fifo.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d items (%0d ticks, %0d accepted activates/pushes), checked %0d results",
             sent_cnt, tick_cnt, hit_cnt, result_cnt);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
